// ===== design/pnft_pkg.sv =====
package pnft_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int WIN_BITS      = 13;
  localparam int NUM_CH        = 4;
  localparam int NUM_EV        = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_SIGN_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR_INIT   = 2'd3;

  // rectifier modes
  localparam logic [1:0] SIGN_CLAMP_NEG = 2'd0;
  localparam logic [1:0] SIGN_CLAMP_POS = 2'd1;
  localparam logic [1:0] SIGN_ABS       = 2'd2;

  localparam logic [1:0]                    SIGN_MODE_RST    = SIGN_CLAMP_NEG;
  localparam logic [WIN_BITS-1:0]           WINDOW_START_RST = 13'd4505;
  localparam logic [WIN_BITS-1:0]           WINDOW_END_RST   = 13'd3686;
  localparam logic signed [SAMPLE_BITS-1:0] FLOOR_INIT_RST   = -24'sd5;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_ch0;
    logic signed [SAMPLE_BITS-1:0] sample_ch1;
    logic signed [SAMPLE_BITS-1:0] sample_ch2;
    logic signed [SAMPLE_BITS-1:0] sample_ch3;
    logic                          left_label;
    logic                          right_label;
    logic                          thumb_label;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] noise_ch0;
    logic signed [SAMPLE_BITS-1:0] noise_ch1;
    logic signed [SAMPLE_BITS-1:0] noise_ch2;
    logic signed [SAMPLE_BITS-1:0] noise_ch3;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic red_step;
    logic addr_init;
    logic rd_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic trig_hit;
    logic win_open;
    logic red_big;
    logic scan_last;
    logic pipe_busy;
    logic out_busy;
  } status_t;

endpackage

// ===== design/pnft_ctrl.sv =====
module pnft_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pnft_pkg::status_t status,
  output pnft_pkg::cmd_t    cmd
);

  pnft_pkg::state_t state_r;
  pnft_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pnft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pnft_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // only a rising label with a non-empty window starts a scan
          if (status.trig_hit && status.win_open) begin
            state_nxt = pnft_pkg::ST_REDUCE;
          end else begin
            state_nxt = pnft_pkg::ST_FINISH;
          end
        end
      end
      pnft_pkg::ST_REDUCE: begin
        if (status.red_big) begin
          cmd.red_step = 1'b1;
        end else begin
          cmd.addr_init = 1'b1;
          state_nxt     = pnft_pkg::ST_SCAN;
        end
      end
      pnft_pkg::ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (status.scan_last) begin
          state_nxt = pnft_pkg::ST_DRAIN;
        end
      end
      pnft_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = pnft_pkg::ST_FINISH;
        end
      end
      pnft_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = pnft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pnft_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pnft_datapath.sv =====
module pnft_datapath #(
  parameter int HISTORY_DEPTH = 8192
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pnft_pkg::in_item_t                    in_data,
  input  logic                                  cfg_valid,
  input  logic [pnft_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [pnft_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output pnft_pkg::out_item_t                   out_data,
  input  pnft_pkg::cmd_t                        cmd,
  output pnft_pkg::status_t                     status
);

  localparam int SB = pnft_pkg::SAMPLE_BITS;
  localparam int WB = pnft_pkg::WIN_BITS;
  localparam int NC = pnft_pkg::NUM_CH;
  localparam int NE = pnft_pkg::NUM_EV;
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = (AW > WB) ? AW : WB;
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [CW:0]   DEPTH_X   = (CW+1)'(HISTORY_DEPTH);

  // configuration
  logic [1:0]           sign_mode_r;
  logic [WB-1:0]        win_start_r;
  logic [WB-1:0]        win_end_r;

  // per-item bookkeeping
  logic [AW-1:0]        wp_r;
  logic [AW-1:0]        count_r;
  logic [NE-1:0]        prev_r;
  logic [NE-1:0]        trig_r;
  logic [NE-1:0]        trig_nxt;
  logic [NE-1:0]        labels;

  // scan sequencing
  logic [AW-1:0]        base_r;
  logic [WB-1:0]        red_r;
  logic [WB-1:0]        scan_cnt_r;
  logic [AW-1:0]        addr_r;
  logic [CW:0]          start_x;

  // history and read pipeline
  logic [NC*SB-1:0]     mem [HISTORY_DEPTH];
  logic [NC*SB-1:0]     wr_word;
  logic [NC*SB-1:0]     rd_q_r;
  logic                 v1_r;
  logic                 v2_r;
  logic signed [SB-1:0] rect_r [NC];

  logic signed [SB-1:0] peak_r [NE][NC];
  logic signed [SB-1:0] floor_min [NC];

  logic                 out_valid_r;
  pnft_pkg::out_item_t  out_data_r;

  function automatic logic signed [SB-1:0] rectify(input logic signed [SB-1:0] x,
                                                  input logic [1:0] mode);
    logic signed [SB-1:0] maxv;
    logic signed [SB-1:0] minv;
    logic signed [SB-1:0] res;
    maxv = {1'b0, {(SB-1){1'b1}}};
    minv = {1'b1, {(SB-1){1'b0}}};
    case (mode)
      pnft_pkg::SIGN_CLAMP_NEG: res = (x < 0) ? '0 : x;
      pnft_pkg::SIGN_CLAMP_POS: res = (x > 0) ? '0 : x;
      pnft_pkg::SIGN_ABS: begin
        if (x >= 0) begin
          res = x;
        end else if (x == minv) begin
          res = maxv;
        end else begin
          res = -x;
        end
      end
      default: res = x;
    endcase
    return res;
  endfunction

  function automatic logic signed [SB-1:0] min3(input logic signed [SB-1:0] a,
                                               input logic signed [SB-1:0] b,
                                               input logic signed [SB-1:0] c);
    logic signed [SB-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  assign labels  = {in_data.thumb_label, in_data.right_label, in_data.left_label};
  assign wr_word = {in_data.sample_ch3, in_data.sample_ch2,
                    in_data.sample_ch1, in_data.sample_ch0};

  // rising label while enough history has been written
  always_comb begin
    for (int e = 0; e < NE; e++) begin
      trig_nxt[e] = (CW'(count_r) > CW'(win_start_r)) && labels[e] && !prev_r[e];
    end
  end

  // first scanned address: write slot of the item minus the reduced start distance
  always_comb begin
    if ((CW+1)'(base_r) >= (CW+1)'(red_r)) begin
      start_x = (CW+1)'(base_r) - (CW+1)'(red_r);
    end else begin
      start_x = (CW+1)'(base_r) + DEPTH_X - (CW+1)'(red_r);
    end
  end

  // floor_init has no register of its own: a write reloads the peaks below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_mode_r  <= pnft_pkg::SIGN_MODE_RST;
      win_start_r  <= pnft_pkg::WINDOW_START_RST;
      win_end_r    <= pnft_pkg::WINDOW_END_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pnft_pkg::REG_SIGN_MODE:    sign_mode_r  <= cfg_data[1:0];
        pnft_pkg::REG_WINDOW_START: win_start_r  <= cfg_data[WB-1:0];
        pnft_pkg::REG_WINDOW_END:   win_end_r    <= cfg_data[WB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      count_r <= '0;
      prev_r  <= '0;
      trig_r  <= '0;
    end else if (cmd.accept) begin
      wp_r    <= (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
      count_r <= (count_r == LAST_ADDR) ? count_r : count_r + 1'b1;
      prev_r  <= labels;
      trig_r  <= trig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_r     <= wp_r;
      red_r      <= win_start_r;
      scan_cnt_r <= win_start_r - win_end_r;
    end else begin
      if (cmd.red_step) begin
        red_r <= red_r - WB'(HISTORY_DEPTH);
      end
      if (cmd.rd_issue) begin
        scan_cnt_r <= scan_cnt_r - 1'b1;
      end
    end
    if (cmd.addr_init) begin
      addr_r <= AW'(start_x);
    end else if (cmd.rd_issue) begin
      addr_r <= (addr_r == LAST_ADDR) ? '0 : addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp_r] <= wr_word;
    end
    if (cmd.rd_issue) begin
      rd_q_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      rect_r[c] <= rectify(rd_q_r[c*SB +: SB], sign_mode_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < NE; e++) begin
        for (int c = 0; c < NC; c++) begin
          peak_r[e][c] <= pnft_pkg::FLOOR_INIT_RST;
        end
      end
    end else if (cfg_valid && cfg_index == pnft_pkg::REG_FLOOR_INIT) begin
      for (int e = 0; e < NE; e++) begin
        for (int c = 0; c < NC; c++) begin
          peak_r[e][c] <= cfg_data[SB-1:0];
        end
      end
    end else if (v2_r) begin
      for (int e = 0; e < NE; e++) begin
        for (int c = 0; c < NC; c++) begin
          if (trig_r[e] && rect_r[c] > peak_r[e][c]) begin
            peak_r[e][c] <= rect_r[c];
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      floor_min[c] = min3(peak_r[0][c], peak_r[1][c], peak_r[2][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.noise_ch0 <= floor_min[0];
      out_data_r.noise_ch1 <= floor_min[1];
      out_data_r.noise_ch2 <= floor_min[2];
      out_data_r.noise_ch3 <= floor_min[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.trig_hit  = |trig_nxt;
  assign status.win_open  = win_end_r < win_start_r;
  assign status.red_big   = 32'(red_r) >= 32'(HISTORY_DEPTH);
  assign status.scan_last = scan_cnt_r == WB'(1);
  assign status.pipe_busy = v1_r | v2_r;
  assign status.out_busy  = out_valid_r & ~out_ready;

endmodule

// ===== design/pre_event_noise_floor_tracker_unit.sv =====
// channel  direction  handshake            payload
// in_      input      in_valid / in_ready   pnft_pkg::in_item_t (4 samples, 3 labels)
// out_     output     out_valid / out_ready pnft_pkg::out_item_t (4 noise floors)
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// an item that starts no scan goes to the finish state; there the result register
// loads once no earlier result waits on out_ready; a scanning item first folds
//   window_start modulo the depth, then makes one history read per cycle through the
//   single read port, (window_start - window_end) reads, and drains rd_q_r and rect_r
// reset is synchronous active low; history memory is not cleared, peaks load floor_init
// the result register lets the next item in while a result waits on out_ready
module pre_event_noise_floor_tracker_unit #(
  parameter int HISTORY_DEPTH = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pnft_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output pnft_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pnft_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pnft_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  pnft_pkg::cmd_t    cmd;
  pnft_pkg::status_t status;

  // register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: accept, fold start distance, sweep the window, drain, publish
  pnft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // history memory, peak registers, rectifier and floor minimum
  pnft_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== tb/pnft_floor_checker.sv =====
`timescale 1ns / 1ps

module pnft_floor_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  pnft_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  pnft_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [pnft_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pnft_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  mismatch_count,
  output int                                  floors_awaited,
  output int                                  floors_checked,
  output int                                  window_scans
);

  localparam int HIST_DEPTH = 1 << pnft_pkg::WIN_BITS;

  typedef logic signed [pnft_pkg::SAMPLE_BITS-1:0] sample_t;

  localparam sample_t PEAK_TOP    = {1'b0, {(pnft_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam sample_t PEAK_BOTTOM = {1'b1, {(pnft_pkg::SAMPLE_BITS-1){1'b0}}};

  // shadow of the block's state
  sample_t                       hist_mem [pnft_pkg::NUM_CH][HIST_DEPTH];
  sample_t                       peak_lvl [pnft_pkg::NUM_EV][pnft_pkg::NUM_CH];
  logic [pnft_pkg::NUM_EV-1:0]   labels_prev;
  logic [pnft_pkg::WIN_BITS-1:0] next_index;
  logic [pnft_pkg::WIN_BITS-1:0] wr_ptr;

  // shadow of the registers
  logic [1:0]                    rect_mode;
  logic [pnft_pkg::WIN_BITS-1:0] look_first;
  logic [pnft_pkg::WIN_BITS-1:0] look_stop;
  sample_t                       floor_seed;

  pnft_pkg::out_item_t expected_floors [$];

  function automatic sample_t rectify_sample(sample_t x);
    case (rect_mode)
      pnft_pkg::SIGN_CLAMP_NEG: begin
        if (x < 0) return '0;
        return x;
      end
      pnft_pkg::SIGN_CLAMP_POS: begin
        if (x > 0) return '0;
        return x;
      end
      pnft_pkg::SIGN_ABS: begin
        if (x == PEAK_BOTTOM) return PEAK_TOP;
        if (x < 0) return -x;
        return x;
      end
      default: return x;
    endcase
  endfunction

  task automatic reload_peaks();
    for (int e = 0; e < pnft_pkg::NUM_EV; e++)
      for (int c = 0; c < pnft_pkg::NUM_CH; c++)
        peak_lvl[e][c] = floor_seed;
  endtask

  task automatic fold_window(int ev);
    int      slot;
    sample_t v;
    if (look_stop >= look_first) return;
    window_scans++;
    for (int d = look_first; d > look_stop; d--) begin
      slot = (int'(wr_ptr) - d) & (HIST_DEPTH - 1);
      for (int c = 0; c < pnft_pkg::NUM_CH; c++) begin
        v = rectify_sample(hist_mem[c][slot]);
        if (v > peak_lvl[ev][c]) peak_lvl[ev][c] = v;
      end
    end
  endtask

  task automatic predict_floors(pnft_pkg::in_item_t item);
    sample_t                     s [pnft_pkg::NUM_CH];
    sample_t                     m [pnft_pkg::NUM_CH];
    logic [pnft_pkg::NUM_EV-1:0] lab;
    pnft_pkg::out_item_t         res;
    s   = '{item.sample_ch0, item.sample_ch1, item.sample_ch2, item.sample_ch3};
    lab = {item.thumb_label, item.right_label, item.left_label};
    // sample goes in first, then scans, then labels are remembered
    for (int c = 0; c < pnft_pkg::NUM_CH; c++) hist_mem[c][wr_ptr] = s[c];
    for (int e = 0; e < pnft_pkg::NUM_EV; e++) begin
      if (next_index > look_first && lab[e] && !labels_prev[e]) fold_window(e);
      labels_prev[e] = lab[e];
    end
    wr_ptr = wr_ptr + 1'b1;
    if (next_index != '1) next_index = next_index + 1'b1;
    for (int c = 0; c < pnft_pkg::NUM_CH; c++) begin
      m[c] = peak_lvl[0][c];
      for (int e = 1; e < pnft_pkg::NUM_EV; e++)
        if (peak_lvl[e][c] < m[c]) m[c] = peak_lvl[e][c];
    end
    res.noise_ch0 = m[0];
    res.noise_ch1 = m[1];
    res.noise_ch2 = m[2];
    res.noise_ch3 = m[3];
    expected_floors = {expected_floors, res};
  endtask

  task automatic apply_reg_write(logic [pnft_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [pnft_pkg::CFG_DATA_BITS-1:0] val);
    case (idx)
      pnft_pkg::REG_SIGN_MODE:    rect_mode  = val[1:0];
      pnft_pkg::REG_WINDOW_START: look_first = val[pnft_pkg::WIN_BITS-1:0];
      pnft_pkg::REG_WINDOW_END:   look_stop  = val[pnft_pkg::WIN_BITS-1:0];
      pnft_pkg::REG_FLOOR_INIT: begin
        floor_seed = val[pnft_pkg::SAMPLE_BITS-1:0];
        reload_peaks();
      end
      default: ;
    endcase
  endtask

  task automatic compare_floors(pnft_pkg::out_item_t got);
    pnft_pkg::out_item_t want;
    sample_t             w [pnft_pkg::NUM_CH];
    sample_t             g [pnft_pkg::NUM_CH];
    if (expected_floors.size() == 0) begin
      $display("%0t: unexpected result transaction %h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_floors.pop_front();
    floors_checked++;
    w = '{want.noise_ch0, want.noise_ch1, want.noise_ch2, want.noise_ch3};
    g = '{got.noise_ch0, got.noise_ch1, got.noise_ch2, got.noise_ch3};
    for (int c = 0; c < pnft_pkg::NUM_CH; c++) begin
      if (w[c] !== g[c]) begin
        $display("%0t: noise_ch%0d expected %0d actual %0d", $time, c, w[c], g[c]);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rect_mode   = pnft_pkg::SIGN_MODE_RST;
      look_first  = pnft_pkg::WINDOW_START_RST;
      look_stop   = pnft_pkg::WINDOW_END_RST;
      floor_seed  = pnft_pkg::FLOOR_INIT_RST;
      reload_peaks();
      labels_prev = '0;
      next_index  = '0;
      wr_ptr      = '0;
      expected_floors.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_floors(in_data);
      if (out_valid && out_ready) compare_floors(out_data);
    end
    floors_awaited = expected_floors.size();
  end

endmodule

// ===== tb/pre_event_noise_floor_tracker_unit_tb.sv =====
`timescale 1ns / 1ps

module pre_event_noise_floor_tracker_unit_tb;

  localparam int RUN_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int S_MAX       = 8388607;
  localparam int S_MIN       = -8388608;
  // rectifier code with no defined mode: raw sample passes through
  localparam logic [1:0] SIGN_PASS = 2'd3;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               in_valid  = 1'b0;
  logic                               in_ready;
  pnft_pkg::in_item_t                 in_data   = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  pnft_pkg::out_item_t                out_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [pnft_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [pnft_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

  int mismatch_count;
  int floors_awaited;
  int floors_checked;
  int window_scans;
  int samples_sent = 0;

  // steady: neither side idles; hold_req: receiver stalls for a long stretch
  bit steady   = 1'b0;
  bit hold_req = 1'b0;

  pre_event_noise_floor_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pnft_floor_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .floors_awaited (floors_awaited),
    .floors_checked (floors_checked),
    .window_scans   (window_scans)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("pre_event_noise_floor_tracker_unit_tb failed");
    $finish;
  end

  // result side: random back-pressure, steady stretches, one long hold-off
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // mix of extremes, small values around zero and full-range noise
  function automatic int rand_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return 0;
      3, 4:    return $urandom_range(2000) - 1000;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  // labels mostly hold, flipping now and then so rising edges keep coming
  function automatic logic [2:0] next_labels(logic [2:0] cur);
    logic [2:0] nxt;
    nxt = cur;
    for (int e = 0; e < 3; e++)
      if ($urandom_range(99) < 30) nxt[e] = ~nxt[e];
    return nxt;
  endfunction

  // labs is {left, right, thumb}
  task automatic offer_sample(input int s0, input int s1, input int s2, input int s3,
                              input logic [2:0] labs);
    pnft_pkg::in_item_t item;
    item.sample_ch0  = 24'(s0);
    item.sample_ch1  = 24'(s1);
    item.sample_ch2  = 24'(s2);
    item.sample_ch3  = 24'(s3);
    item.left_label  = labs[2];
    item.right_label = labs[1];
    item.thumb_label = labs[0];
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic offer_random(input logic [2:0] labs);
    offer_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample(), labs);
  endtask

  // sender goes quiet until every noise floor transaction has come back
  task automatic wait_floors_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (floors_awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_reg(input logic [pnft_pkg::CFG_IDX_BITS-1:0] idx,
                          input logic [pnft_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers only change with the block idle; bits above a register's width
  // carry random junk, the block has to ignore them
  task automatic program_regs(input logic [1:0] sm, input int ws, input int we,
                              input int fi, input bit with_floor);
    wait_floors_drained();
    push_reg(pnft_pkg::REG_SIGN_MODE,    {22'($urandom), sm});
    push_reg(pnft_pkg::REG_WINDOW_START, {11'($urandom), 13'(ws)});
    push_reg(pnft_pkg::REG_WINDOW_END,   {11'($urandom), 13'(we)});
    if (with_floor) push_reg(pnft_pkg::REG_FLOOR_INIT, 24'(fi));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [2:0] labs;
    logic [1:0] sm;
    int         ws;
    int         we;
    int         fi;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: window far beyond the sample count, floors stay at init
    offer_random(3'b111);
    offer_random(3'b000);

    // short window with absolute value, floor at the bottom
    program_regs(pnft_pkg::SIGN_ABS, 4, 0, S_MIN, 1'b1);
    offer_sample(S_MAX, S_MIN, 0, -1, 3'b000);
    offer_sample(S_MIN, S_MAX, 1, -1, 3'b000);
    offer_sample(0, 0, 0, 0, 3'b000);
    offer_sample(123, -456, 789, -1011, 3'b000);
    // most negative sample inside the window saturates under absolute value
    offer_sample(S_MIN, S_MIN, S_MIN, S_MIN, 3'b100);
    offer_sample(5, -5, 7, -7, 3'b110);
    offer_sample(-2, 2, -3, 3, 3'b011);
    offer_sample(9, 9, 9, 9, 3'b111);

    // clamp positives, window not reaching back to the newest entries
    program_regs(pnft_pkg::SIGN_CLAMP_POS, 6, 2, -100, 1'b1);
    offer_sample(-50, 40, -30, 20, 3'b000);
    offer_sample(-1, -1, -1, -1, 3'b111);
    offer_sample(S_MIN, 0, 1, S_MAX, 3'b000);

    // unused rectifier code passes raw samples
    program_regs(SIGN_PASS, 3, 0, S_MIN, 1'b1);
    offer_sample(-7, S_MAX, -9, 11, 3'b010);
    offer_sample(3, -3, S_MIN, 0, 3'b101);

    // empty window: stop distance equals start distance, peaks untouched
    program_regs(pnft_pkg::SIGN_ABS, 3, 3, 0, 1'b0);
    offer_sample(1, 2, 3, 4, 3'b000);
    offer_sample(S_MAX, S_MAX, S_MAX, S_MAX, 3'b111);

    // floor at the top: no peak can grow past it
    program_regs(pnft_pkg::SIGN_CLAMP_NEG, 5, 1, S_MAX, 1'b1);
    offer_sample(S_MAX, -1, 0, 1, 3'b000);
    offer_sample(4, 4, 4, 4, 3'b111);

    // largest start distance: index never gets past it this early
    program_regs(pnft_pkg::SIGN_ABS, 8191, 0, 0, 1'b1);
    offer_sample(S_MIN, S_MIN, S_MIN, S_MIN, 3'b000);
    offer_sample(S_MAX, S_MAX, S_MAX, S_MAX, 3'b111);

    // random segments with fresh settings each time
    labs = 3'b000;
    for (int seg = 0; seg < 7; seg++) begin
      sm = 2'($urandom_range(3));
      case ($urandom_range(5))
        0:       ws = 1;
        1:       ws = $urandom_range(2, 12);
        2:       ws = $urandom_range(13, 48);
        3:       ws = $urandom_range(49, 150);
        4:       ws = 24;
        default: ws = $urandom_range(1, 40);
      endcase
      case ($urandom_range(4))
        0:       we = 0;
        1:       we = ws;
        2:       we = $urandom_range(0, ws - 1);
        3:       we = $urandom_range(ws, ws + 5);
        default: we = ws - 1;
      endcase
      fi = rand_sample();
      program_regs(sm, ws, we, fi, 1'($urandom_range(1)));
      steady = (seg == 2);
      for (int k = 0; k < 17; k++) begin
        // long receiver stall while samples keep coming: block must back up
        if (seg == 4 && k == 5) hold_req = 1'b1;
        // sender pause until everything outstanding has returned
        if (seg == 5 && k == 10) wait_floors_drained();
        labs = next_labels(labs);
        offer_random(labs);
      end
    end
    steady = 1'b0;

    wait_floors_drained();
    repeat (16) @(posedge clk);

    $display("run covered %0d samples, %0d noise floor transactions checked, %0d window scans",
             samples_sent, floors_checked, window_scans);
    $display("included all sign modes, empty windows, floor reloads, a long stall and a drain");
    if (mismatch_count == 0) begin
      $display("pre_event_noise_floor_tracker_unit_tb passed");
    end else begin
      $display("pre_event_noise_floor_tracker_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pnft_pkg.sv
design/pnft_ctrl.sv
design/pnft_datapath.sv
design/pre_event_noise_floor_tracker_unit.sv
tb/pnft_floor_checker.sv
tb/pre_event_noise_floor_tracker_unit_tb.sv
